FILE: sv/dtd_pkg.sv
// shared types and constants for the decimal digit register writer
// no dependencies; imported by every other file of the block
package dtd_pkg;

    localparam int VALUE_W    = 32;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 8;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 8;
    localparam int BCD_DIGITS = 10;
    localparam int IDX_W      = $clog2(BCD_DIGITS + 1);
    localparam int CNT_W      = $clog2(VALUE_W + 1);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // command codes
    localparam logic CMD_SIGNED = 1'b0;
    localparam logic CMD_FIXED  = 1'b1;

    // driver register map and data codes
    localparam logic [ADDR_W-1:0] ADDR_DECODE = 4'd9;
    localparam logic [DATA_W-1:0] CODE_MINUS  = 8'd10;
    localparam logic [DATA_W-1:0] DECODE_ALL  = 8'hFF;
    localparam logic [DATA_W-1:0] DECODE_NONE = 8'h00;

    // config register byte address
    localparam logic [PADDR_W-1:0] CFG_ADDR_RESTORE = 3'd0;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    // classified item as it sits in the queue
    typedef struct packed {
        logic               fixed;
        logic               neg;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] mag;
        logic [IDX_W-1:0]   count;
    } t_desc;

    // one driver register write
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
        logic [POS_W-1:0]  endp;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_HEADER,
        ST_MINUS,
        ST_DIGITS,
        ST_FINAL
    } t_back_state;

endpackage

FILE: sv/dtd_in_if.sv
// input channel: number, start position and print command
// depends on dtd_pkg
interface dtd_in_if import dtd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [POS_W-1:0]   start_position;
    logic [VALUE_W-1:0] value_word;
    logic [COUNT_W-1:0] digit_count;

    modport source (output valid, command, start_position, value_word, digit_count,
                    input ready);
    modport sink   (input valid, command, start_position, value_word, digit_count,
                    output ready);
endinterface

FILE: sv/dtd_out_if.sv
// output channel: one driver register write per beat
// depends on dtd_pkg
interface dtd_out_if import dtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] reg_data;
    logic              last_write;
    logic [POS_W-1:0]  end_position;

    modport source (output valid, reg_addr, reg_data, last_write, end_position,
                    input ready);
    modport sink   (input valid, reg_addr, reg_data, last_write, end_position,
                    output ready);
endinterface

FILE: sv/dtd_queue.sv
// short fifo of classified items between front and back
// depends on dtd_pkg
module dtd_queue import dtd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_push_desc,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]  r_fill, n_fill;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

FILE: sv/dtd_front.sv
// front end: accepts input beats and classifies them into queue entries
// depends on dtd_pkg and dtd_in_if
module dtd_front import dtd_pkg::*; #(
    parameter int DIGIT_POSITIONS    = 8,
    parameter int MAX_DECIMAL_DIGITS = 10
) (
    dtd_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_desc  o_desc
);

    localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(DIGIT_POSITIONS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DECIMAL_DIGITS);

    logic fixed_mode;
    logic negative;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    assign fixed_mode = (i_in.command == CMD_FIXED);
    assign negative   = !fixed_mode && i_in.value_word[VALUE_W-1];

    always_comb begin
        o_desc.fixed = fixed_mode;
        o_desc.neg   = negative;
        // positions beyond the display saturate
        o_desc.pos   = (i_in.start_position > POS_MAX) ? POS_MAX : i_in.start_position;
        // most negative value wraps to itself and is then read unsigned
        o_desc.mag   = negative ? (~i_in.value_word + 1'b1) : i_in.value_word;
        if (!fixed_mode) begin
            o_desc.count = '0;
        end else if (i_in.digit_count > COUNT_MAX) begin
            o_desc.count = IDX_W'(MAX_DECIMAL_DIGITS);
        end else begin
            o_desc.count = i_in.digit_count[IDX_W-1:0];
        end
    end

endmodule

FILE: sv/dtd_bcd.sv
// iterative binary to bcd converter, shift and add-3, one bit per cycle
// depends on dtd_pkg
module dtd_bcd import dtd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_done,
    output t_bcd               o_bcd
);

    logic [VALUE_W-1:0]      r_bin, n_bin;
    t_bcd                    r_bcd, n_bcd;
    t_bcd                    adj;
    logic [BCD_DIGITS*4-1:0] adj_bits;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_done, n_done;

    assign o_done   = r_done;
    assign o_bcd    = r_bcd;
    assign adj_bits = adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_bin = i_value;
            n_bcd = '0;
            n_cnt = CNT_W'(VALUE_W);
        end else if (r_cnt != '0) begin
            n_bcd  = {adj_bits[BCD_DIGITS*4-2:0], r_bin[VALUE_W-1]};
            n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

endmodule

FILE: sv/dtd_back.sv
// back end: sequences the register writes of one item into an output register
// depends on dtd_pkg, dtd_out_if and dtd_bcd
module dtd_back import dtd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_restore_all,
    input  logic      i_q_empty,
    input  t_desc     i_q_head,
    output logic      o_pop,
    dtd_out_if.source o_out
);

    t_back_state      r_state, n_state;
    t_desc            r_desc, n_desc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] idx_m1;
    logic             r_out_valid, n_out_valid;
    t_wr              r_wr, n_wr;
    logic             can_load;
    logic             bcd_start;
    logic             bcd_done;
    t_bcd             bcd;
    logic [IDX_W-1:0] sig_digits;

    dtd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_value (i_q_head.mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.reg_addr     = r_wr.addr;
    assign o_out.reg_data     = r_wr.data;
    assign o_out.last_write   = r_wr.last;
    assign o_out.end_position = r_wr.endp;

    assign can_load = !r_out_valid || o_out.ready;
    assign idx_m1   = r_idx - 1'b1;

    // significant digits, at least one so that zero prints
    always_comb begin
        sig_digits = IDX_W'(1);
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (bcd[i] != 4'd0) begin
                sig_digits = IDX_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_desc      = r_desc;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_wr        = r_wr;
        o_pop       = 1'b0;
        bcd_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop     = 1'b1;
                    bcd_start = 1'b1;
                    n_desc    = i_q_head;
                    n_pos     = i_q_head.pos;
                    n_state   = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (bcd_done) begin
                    n_idx   = r_desc.fixed ? r_desc.count : sig_digits;
                    n_state = ST_HEADER;
                end
            end
            ST_HEADER: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_wr        = '{addr: ADDR_DECODE, data: DECODE_ALL, last: 1'b0, endp: '0};
                    n_state     = r_desc.neg ? ST_MINUS : ST_DIGITS;
                end
            end
            ST_MINUS: begin
                if (r_pos == '0) begin
                    n_state = ST_DIGITS;
                end else if (can_load) begin
                    n_out_valid = 1'b1;
                    n_wr        = '{addr: r_pos, data: CODE_MINUS, last: 1'b0, endp: '0};
                    n_pos       = r_pos - 1'b1;
                    n_state     = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (r_idx == '0 || r_pos == '0) begin
                    n_state = ST_FINAL;
                end else if (can_load) begin
                    n_out_valid = 1'b1;
                    n_wr        = '{addr: r_pos, data: DATA_W'(bcd[idx_m1]),
                                    last: 1'b0, endp: '0};
                    n_pos       = r_pos - 1'b1;
                    n_idx       = idx_m1;
                end
            end
            ST_FINAL: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_wr        = '{addr: ADDR_DECODE,
                                    data: i_restore_all ? DECODE_ALL : DECODE_NONE,
                                    last: 1'b1, endp: r_pos};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_wr   <= n_wr;
    end

endmodule

FILE: sv/decimal_to_digit_register_writes_unit.sv
// Turns a number into the register writes that show it on a decoding
// seven-segment display driver. Each input beat carries a command (signed
// without leading zeros, or unsigned with a fixed, zero-padded digit count
// clamped to MAX_DECIMAL_DIGITS), a start digit position (saturated to
// DIGIT_POSITIONS) and the value. The block answers with 2 to 10 output
// beats: decode-all on address 9, an optional minus code, the digits most
// significant first on descending positions until position 0 is reached
// (the rest are dropped), and a last write that restores the configured
// decode mode and reports the position left. An item leaves the queue,
// goes through the one-bit-per-cycle binary to bcd converter, and then
// has its writes issued at most one per cycle, held while the output is
// not ready. The back end handles one item at a time; a two-entry queue
// in front lets new items be accepted meanwhile. The restore mode register
// sits at byte address 0 of the apb port and may be written only while the
// block is idle.
// depends on dtd_pkg, dtd_in_if, dtd_out_if, dtd_queue, dtd_front, dtd_back
module decimal_to_digit_register_writes_unit import dtd_pkg::*; #(
    parameter int DIGIT_POSITIONS    = 8,
    parameter int MAX_DECIMAL_DIGITS = 10,
    parameter int QUEUE_DEPTH        = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // apb config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // item channels
    dtd_in_if.sink             i_in,
    dtd_out_if.source          o_out
);

    logic  r_restore_all;
    logic  cfg_hit;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_desc q_push_desc;
    t_desc q_head;

    // config register: single bit, written on the access phase
    assign pready  = 1'b1;
    assign cfg_hit = (paddr == CFG_ADDR_RESTORE);
    assign prdata  = cfg_hit ? PDATA_W'(r_restore_all) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restore_all <= 1'b0;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_restore_all <= pwdata[0];
        end
    end

    // front end: accept and classify a beat
    dtd_front #(
        .DIGIT_POSITIONS    (DIGIT_POSITIONS),
        .MAX_DECIMAL_DIGITS (MAX_DECIMAL_DIGITS)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_desc   (q_push_desc)
    );

    // decouples acceptance from the slow back end
    dtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_desc (q_push_desc),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    // back end: conversion and write sequencing
    dtd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restore_all (r_restore_all),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_pop         (q_pop),
        .o_out         (o_out)
    );

    // the restore write is the only one flagged last, and it goes to decode mode
    a_last_is_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_write |-> o_out.reg_addr == ADDR_DECODE)
        else $error("last write not on decode mode register");

    // digit writes stay on the display
    a_digit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.reg_addr != ADDR_DECODE |->
            o_out.reg_addr != '0 && o_out.reg_addr <= POS_W'(DIGIT_POSITIONS))
        else $error("digit write outside display");

    // end position only reported on the last write
    a_endp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last_write |-> o_out.end_position == '0)
        else $error("end position set on a non-final write");

    // the queue never pops when empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

FILE: verif/decimal_to_digit_register_writes_unit_test.sv
`timescale 1ns / 100ps
// testbench for decimal_to_digit_register_writes_unit: directed and random print
// commands, a scoreboard class that predicts every driver register write
// depends on dtd_pkg, dtd_in_if, dtd_out_if and the unit itself
module decimal_to_digit_register_writes_unit_test;
    import dtd_pkg::*;

    localparam int DISPLAY_DIGITS = 8;
    localparam int MAX_DIGITS     = 10;
    // settle time after the last expected write, above the worst item latency
    localparam int SETTLE_CYCLES  = 60;
    // worst case is roughly 425 items, each with conversion and up to 10 stalled writes, many times over
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLD_CYCLES    = 300;

    // one print command as offered on the input channel
    typedef struct {
        logic               command;
        logic [POS_W-1:0]   start_position;
        logic [VALUE_W-1:0] value_word;
        logic [COUNT_W-1:0] digit_count;
    } t_print_item;

    // predicts the write run of each accepted command and checks the writes
    class display_write_board;
        t_wr  pending_writes[$];
        logic restore_all;
        int   fail_count;

        function new();
            restore_all = 1'b0;
            fail_count  = 0;
        endfunction

        // a digit lands on the current position while one is left
        function void place_digit(inout logic [POS_W-1:0] pos, input logic [DATA_W-1:0] code);
            if (pos != 0) begin
                pending_writes.push_back('{addr: pos, data: code, last: 1'b0, endp: '0});
                pos = pos - 1'b1;
            end
        endfunction

        function void note_item(t_print_item it);
            logic [POS_W-1:0]   pos;
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digits[$];
            int                 n;
            longint unsigned    scale;

            pos = (it.start_position > DISPLAY_DIGITS) ? POS_W'(DISPLAY_DIGITS)
                                                      : it.start_position;
            pending_writes.push_back('{addr: ADDR_DECODE, data: DECODE_ALL,
                                       last: 1'b0, endp: '0});
            if (it.command == CMD_SIGNED) begin
                mag = it.value_word;
                if (it.value_word[VALUE_W-1]) begin
                    place_digit(pos, CODE_MINUS);
                    mag = -it.value_word;
                end
                // least significant first, so push to the front
                do begin
                    digits.push_front(4'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0);
                foreach (digits[i])
                    place_digit(pos, DATA_W'(digits[i]));
            end else begin
                n = (it.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(it.digit_count);
                for (int k = n; k > 0; k--) begin
                    scale = 1;
                    repeat (k - 1) scale = scale * 10;
                    place_digit(pos, DATA_W'((longint'(it.value_word) / scale) % 10));
                end
            end
            pending_writes.push_back('{addr: ADDR_DECODE,
                                       data: restore_all ? DECODE_ALL : DECODE_NONE,
                                       last: 1'b1, endp: pos});
        endfunction

        function void check_write(t_wr got);
            t_wr want;
            if (pending_writes.size() == 0) begin
                $error("unexpected write: reg_addr %0d reg_data %0d last_write %0d",
                       got.addr, got.data, got.last);
                fail_count++;
                return;
            end
            want = pending_writes.pop_front();
            if (got.addr !== want.addr) begin
                $error("reg_addr: expected %0d, got %0d", want.addr, got.addr);
                fail_count++;
            end
            if (got.data !== want.data) begin
                $error("reg_data: expected %0d, got %0d", want.data, got.data);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last_write: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
            if (got.endp !== want.endp) begin
                $error("end_position: expected %0d, got %0d", want.endp, got.endp);
                fail_count++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dtd_in_if  in_ch ();
    dtd_out_if out_ch ();

    display_write_board board;

    // idle and stall odds in percent, set per phase
    int  send_idle_pct;
    int  sink_stall_pct;
    // long hold-off on the write side, counted down in the ready process
    bit  hold_request;
    int  hold_left;
    int  cycle_count;

    decimal_to_digit_register_writes_unit #(
        .DIGIT_POSITIONS    (DISPLAY_DIGITS),
        .MAX_DECIMAL_DIGITS (MAX_DIGITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // write side ready: random stalls, or a long hold when asked for
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // every write beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_write('{addr: out_ch.reg_addr, data: out_ch.reg_data,
                                last: out_ch.last_write, endp: out_ch.end_position});
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one command, with random idle cycles ahead of it, until accepted
    task send_item(t_print_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= it.command;
        in_ch.start_position <= it.start_position;
        in_ch.value_word     <= it.value_word;
        in_ch.digit_count    <= it.digit_count;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_item(it);
    endtask

    task send_print(logic cmd, int pos, logic [VALUE_W-1:0] val, int cnt);
        t_print_item it;
        it.command        = cmd;
        it.start_position = POS_W'(pos);
        it.value_word     = val;
        it.digit_count    = COUNT_W'(cnt);
        send_item(it);
    endtask

    // random commands, weighted toward positions on the display and short counts
    task send_random_items(int total);
        t_print_item it;
        repeat (total) begin
            it.command        = 1'($urandom_range(1));
            it.start_position = ($urandom_range(9) == 0) ? POS_W'($urandom_range(15))
                                                         : POS_W'($urandom_range(DISPLAY_DIGITS));
            case ($urandom_range(4))
                0: it.value_word = $urandom;
                1: it.value_word = $urandom_range(9999);
                2: it.value_word = -$urandom_range(9999);
                3: it.value_word = 32'h8000_0000 + $urandom_range(3) - 2;
                default: it.value_word = ~VALUE_W'($urandom_range(255));
            endcase
            it.digit_count = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(255))
                                                      : COUNT_W'($urandom_range(MAX_DIGITS + 1));
            send_item(it);
        end
    endtask

    // drop valid, wait for every expected write, then let the block settle
    task drain_writes();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the restore mode, then read it back
    task write_restore_mode(logic mode);
        logic [PDATA_W-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_RESTORE;
        pwdata  <= PDATA_W'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.restore_all = mode;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== PDATA_W'(mode)) begin
            $error("restore_decode_all: expected %0d, got %0d", mode, readback);
            board.fail_count++;
        end
    endtask

    initial begin
        board          = new();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_request   = 1'b0;
        hold_left      = 0;
        // every input known from time zero
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_SIGNED;
        in_ch.start_position = '0;
        in_ch.value_word     = '0;
        in_ch.digit_count    = '0;
        out_ch.ready         = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, restore mode still at its reset value for the first few
        send_print(CMD_SIGNED, 8, 32'd0, 0);                  // zero prints one digit
        send_print(CMD_SIGNED, 8, 32'd1, 0);
        send_print(CMD_SIGNED, 8, 32'hFFFF_FFFF, 0);          // minus one
        drain_writes();
        write_restore_mode(1'b1);
        send_print(CMD_SIGNED, 8, 32'h8000_0000, 0);          // most negative, digits dropped
        send_print(CMD_SIGNED, 8, 32'h7FFF_FFFF, 0);
        send_print(CMD_SIGNED, 8, 32'd1000000000, 255);       // ten digits, count ignored
        send_print(CMD_SIGNED, 3, 32'd12345, 0);              // runs off the display
        send_print(CMD_SIGNED, 1, -32'd5, 0);                 // only the minus fits
        send_print(CMD_SIGNED, 0, 32'd42, 0);                 // no position at all
        send_print(CMD_SIGNED, 15, 32'd7, 0);                 // position saturates
        send_print(CMD_SIGNED, 9, -32'd99, 0);
        send_print(CMD_FIXED, 8, 32'd0, 0);                   // zero count, no digits
        send_print(CMD_FIXED, 8, 32'hFFFF_FFFF, 10);
        send_print(CMD_FIXED, 15, 32'hFFFF_FFFF, 255);        // count clamps to ten
        send_print(CMD_FIXED, 8, 32'd1234, 11);               // leading zero padding
        send_print(CMD_FIXED, 2, 32'd56, 3);
        send_print(CMD_FIXED, 1, 32'd9, 1);
        send_print(CMD_FIXED, 8, 32'd4294967295, 9);
        send_print(CMD_FIXED, 8, 32'd1000000000, 10);
        send_print(CMD_FIXED, 0, 32'd31415, 5);
        send_print(CMD_FIXED, 6, 32'hAAAA_5555, 128);
        drain_writes();

        // back to back with a long write-side hold so the input stalls
        write_restore_mode(1'b0);
        hold_request = 1'b1;
        send_random_items(12);
        send_random_items(88);
        drain_writes();

        // sender mostly idle
        write_restore_mode(1'b1);
        send_idle_pct = 80;
        send_random_items(100);
        drain_writes();

        // receiver mostly stalled
        write_restore_mode(1'b0);
        send_idle_pct  = 0;
        sink_stall_pct = 80;
        send_random_items(100);
        drain_writes();

        // both sides idle at random
        write_restore_mode(1'b1);
        send_idle_pct  = 38;
        sink_stall_pct = 38;
        send_random_items(100);
        drain_writes();

        if (board.fail_count == 0 && board.pending_writes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/dtd_pkg.sv
sv/dtd_in_if.sv
sv/dtd_out_if.sv
sv/dtd_queue.sv
sv/dtd_front.sv
sv/dtd_bcd.sv
sv/dtd_back.sv
sv/decimal_to_digit_register_writes_unit.sv
verif/decimal_to_digit_register_writes_unit_test.sv
